@@ rtl/kli_pkg.sv @@
// ----------------------------------------------------------------------------
// kli_pkg: shared types and constants of the keyframe latency index table.
// Holds the entry format, the per-cell operation codes, the request codes and
// the packing of the stream payloads.
// ----------------------------------------------------------------------------
package kli_pkg;

    // Default number of table entries.
    localparam int DEPTH_DEF = 64;

    // Field widths.
    localparam int REQ_W   = 2;
    localparam int IDX_W   = 31;
    localparam int TS_W    = 32;
    localparam int LAT_W   = 31;
    localparam int GLEN_W  = 20;
    localparam int HELD_W  = 7;

    // Saturation value of the group length counters.
    localparam logic [GLEN_W-1:0] GLEN_MAX = {GLEN_W{1'b1}};

    // Payload widths on the stream ports.
    localparam int S_DATA_BITS  = IDX_W + TS_W + LAT_W + IDX_W;
    localparam int S_DATA_W     = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int S_USER_W     = 8;
    localparam int M_DATA_BITS  = 1 + IDX_W + LAT_W + GLEN_W + HELD_W + 1;
    localparam int M_DATA_W     = ((M_DATA_BITS + 7) / 8) * 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // One stored keyframe entry; live marks a slot that survives a clear.
    typedef struct packed {
        logic             live;
        logic [IDX_W-1:0] idx;
        logic [TS_W-1:0]  ts;
    } kli_entry_t;

    // What every cell of the chain does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_PUSH   = 2'd1,
        CELL_ROTATE = 2'd2,
        CELL_PACK   = 2'd3
    } kli_cell_op_t;

    // Control from the sequencer to the head unit.
    typedef struct packed {
        logic start;
        logic query;
        logic clear;
        logic in_range;
    } kli_head_ctl_t;

endpackage

@@ rtl/kli_cell.sv @@
// ----------------------------------------------------------------------------
// kli_cell: one cell of the entry chain.
// Holds one keyframe entry. Takes its neighbor's entry on a push (toward the
// older end) or on a rotate and pack (toward the newest end).
// ----------------------------------------------------------------------------
module kli_cell
    import kli_pkg::*;
(
    input  logic         clk,
    input  kli_cell_op_t op,
    input  kli_entry_t   prev_entry,
    input  kli_entry_t   next_entry,
    output kli_entry_t   entry
);

    kli_entry_t entry_reg;
    kli_entry_t entry_next;

    // Next entry of this cell.
    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            CELL_PUSH:
            begin
                entry_next = prev_entry;
            end
            CELL_ROTATE:
            begin
                entry_next = next_entry;
            end
            CELL_PACK:
            begin
                // A hole pulls the older-side neighbor in; an entry behind a
                // hole moves on and leaves a hole.
                if (!entry_reg.live)
                begin
                    entry_next = next_entry;
                end
                else if (!prev_entry.live)
                begin
                    entry_next.live = 1'b0;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/kli_head.sv @@
// ----------------------------------------------------------------------------
// kli_head: evaluation unit at the head of the entry chain.
// Looks at the entry leaving the head cell once per cycle while the ring
// rotates: tracks the oldest qualifying entry of a query, marks kept entries
// of a clear and feeds the tail cell.
// ----------------------------------------------------------------------------
module kli_head
    import kli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  kli_head_ctl_t        ctl,
    input  kli_entry_t           head_entry,
    input  logic [TS_W-1:0]      newest_time,
    input  logic [LAT_W-1:0]     latency_limit,
    input  logic [IDX_W-1:0]     min_index,
    output kli_entry_t           tail_entry,
    output logic                 found,
    output logic [IDX_W-1:0]     gop_index,
    output logic [LAT_W-1:0]     gop_latency,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] kept
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic             found_reg;
    logic [IDX_W-1:0] gidx_reg;
    logic [LAT_W-1:0] glat_reg;
    logic             run_ok_reg;
    logic [LAT_W-1:0] limit_reg;
    logic [IDX_W-1:0] bound_reg;
    logic [CNT_W-1:0] kept_reg;

    logic [TS_W-1:0]  diff;
    logic             negative;
    logic             qualifies;
    logic             keep;

    // Latency of the head entry as a signed difference.
    always_comb
    begin
        diff      = newest_time - head_entry.ts;
        negative  = diff[TS_W-1];
        qualifies = ctl.in_range && run_ok_reg &&
                    (negative || (diff[LAT_W-1:0] <= limit_reg));
        keep      = ctl.in_range && (head_entry.idx > bound_reg);
    end

    // Entry written back into the tail cell.
    always_comb
    begin
        tail_entry = head_entry;
        if (ctl.query)
        begin
            tail_entry.live = head_entry.live;
        end
        else if (ctl.clear)
        begin
            tail_entry.live = keep;
        end
        else
        begin
            tail_entry.live = 1'b0;
        end
    end

    // Running search and count state, set up when a transaction is taken.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            found_reg  <= 1'b0;
            gidx_reg   <= '0;
            glat_reg   <= '0;
            run_ok_reg <= 1'b1;
            kept_reg   <= '0;
            limit_reg  <= latency_limit;
            bound_reg  <= min_index;
        end
        else if (ctl.query)
        begin
            if (qualifies)
            begin
                found_reg <= 1'b1;
                gidx_reg  <= head_entry.idx;
                glat_reg  <= negative ? '0 : diff[LAT_W-1:0];
            end
            else
            begin
                run_ok_reg <= 1'b0;
            end
        end
        else if (ctl.clear)
        begin
            if (keep)
            begin
                kept_reg <= kept_reg + CNT_W'(1);
            end
        end
    end

    assign found       = found_reg;
    assign gop_index   = gidx_reg;
    assign gop_latency = glat_reg;
    assign kept        = kept_reg;

endmodule

@@ rtl/keyframe_latency_index_table.sv @@
// ----------------------------------------------------------------------------
// keyframe_latency_index_table: bounded table of keyframe entries.
// Entries sit in a chain of cells, newest at the head. Adds push into the
// chain, queries and clears rotate the ring past one evaluation unit, and a
// clear then packs the surviving entries toward the head.
//
//   Channel   Direction  Handshake           Payload
//   s_*       in         s_tvalid/s_tready   request fields (tdata, tuser)
//   m_*       out        m_tvalid/m_tready   result fields (tdata)
//
// An add and the unused request code go straight to the finish step; a query
// turns the ring once, one cell per cycle, past the single comparator at the
// head, and a clear turns it once and then runs the pack pass.
// Reset clears the control state only; the cells are not cleared and need no
// pass after reset. A new transaction is taken while a result waits; a
// result that is not taken holds the block at its final step.
// ----------------------------------------------------------------------------
module keyframe_latency_index_table
    import kli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // frame_index, frame_timestamp, latency_limit, min_index, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // req_type, is_key_frame, zero pad
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // found, gop_index, gop_latency, max_gop_length, entries_held,
    // dropped_oldest, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int STEP_W = $clog2(TABLE_DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_QUERY  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_PACK   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // Request fields.
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] frame_index;
    logic [TS_W-1:0]  frame_timestamp;
    logic             is_key_frame;
    logic [LAT_W-1:0] latency_limit;
    logic [IDX_W-1:0] min_index;

    assign req_type        = s_tuser[1:0];
    assign is_key_frame    = s_tuser[2];
    assign frame_index     = s_tdata[30:0];
    assign frame_timestamp = s_tdata[62:31];
    assign latency_limit   = s_tdata[93:63];
    assign min_index       = s_tdata[124:94];

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TS_W-1:0]   newest_reg, newest_next;
    logic [GLEN_W-1:0] cur_len_reg, cur_len_next;
    logic [GLEN_W-1:0] max_len_reg, max_len_next;
    logic              dropped_reg, dropped_next;
    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;

    logic              accept;
    logic              last_step;
    logic              out_free;
    kli_cell_op_t      cell_op;
    kli_head_ctl_t     head_ctl;
    kli_entry_t        push_entry;
    kli_entry_t        tail_entry;
    kli_entry_t        cells [TABLE_DEPTH];

    logic              found;
    logic [IDX_W-1:0]  gop_index;
    logic [LAT_W-1:0]  gop_latency;
    logic [CNT_W-1:0]  kept;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign last_step = (step_reg == LAST_STEP);
    assign out_free  = !m_valid_reg || m_tready;

    // New entry offered to the head cell.
    always_comb
    begin
        push_entry.live = 1'b1;
        push_entry.idx  = frame_index;
        push_entry.ts   = frame_timestamp;
    end

    // Chain of entry cells, head at index zero.
    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        kli_entry_t prev_in;
        kli_entry_t next_in;
        if (g == 0)
        begin : g_first
            assign prev_in = push_entry;
        end
        else
        begin : g_mid_prev
            assign prev_in = cells[g-1];
        end
        if (g == TABLE_DEPTH - 1)
        begin : g_last
            assign next_in = tail_entry;
        end
        else
        begin : g_mid_next
            assign next_in = cells[g+1];
        end
        kli_cell u_cell (
            .clk        (clk),
            .op         (cell_op),
            .prev_entry (prev_in),
            .next_entry (next_in),
            .entry      (cells[g])
        );
    end

    // Control to the head unit.
    always_comb
    begin
        head_ctl.start    = accept;
        head_ctl.query    = (state_reg == ST_QUERY);
        head_ctl.clear    = (state_reg == ST_SCAN);
        head_ctl.in_range = (CNT_W'(step_reg) < count_reg);
    end

    kli_head #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_head (
        .clk           (clk),
        .ctl           (head_ctl),
        .head_entry    (cells[0]),
        .newest_time   (newest_reg),
        .latency_limit (latency_limit),
        .min_index     (min_index),
        .tail_entry    (tail_entry),
        .found         (found),
        .gop_index     (gop_index),
        .gop_latency   (gop_latency),
        .kept          (kept)
    );

    // Sequencer and table status.
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        newest_next  = newest_reg;
        cur_len_next = cur_len_reg;
        max_len_next = max_len_reg;
        dropped_next = dropped_reg;
        m_valid_next = m_valid_reg;
        cell_op      = CELL_HOLD;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    dropped_next = 1'b0;
                    step_next    = '0;
                    case (req_type)
                        REQ_ADD:
                        begin
                            newest_next = frame_timestamp;
                            if (is_key_frame)
                            begin
                                cell_op = CELL_PUSH;
                                if (count_reg >= FULL_CNT)
                                begin
                                    dropped_next = 1'b1;
                                end
                                else
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                                if (cur_len_reg > max_len_reg)
                                begin
                                    max_len_next = cur_len_reg;
                                end
                                cur_len_next = GLEN_W'(1);
                            end
                            else if (cur_len_reg != GLEN_MAX)
                            begin
                                cur_len_next = cur_len_reg + GLEN_W'(1);
                            end
                            state_next = ST_FINISH;
                        end
                        REQ_QUERY:
                        begin
                            state_next = ST_QUERY;
                        end
                        REQ_CLEAR:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_QUERY:
            begin
                cell_op   = CELL_ROTATE;
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cell_op   = CELL_ROTATE;
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                cell_op   = CELL_PACK;
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    step_next  = '0;
                    count_next = kept;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            newest_reg  <= '0;
            cur_len_reg <= '0;
            max_len_reg <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            newest_reg  <= newest_next;
            cur_len_reg <= cur_len_next;
            max_len_reg <= max_len_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result register, loaded when the finish step hands over.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            m_data_reg <= M_DATA_W'({dropped_reg, HELD_W'(count_reg), max_len_reg,
                                     gop_latency, gop_index, found});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/kli_checker.sv @@
// ----------------------------------------------------------------------------
// kli_checker: port-level checks of the keyframe latency index table.
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module kli_checker
    import kli_pkg::*;
#(
    parameter int TABLE_DEPTH = DEPTH_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic              seen_reg;
    logic [GLEN_W-1:0] last_max_reg;

    // Longest group length of the last delivered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_max_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            seen_reg     <= 1'b1;
            last_max_reg <= m_tdata[82:63];
        end
    end

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Without a match the index and latency read zero.
    a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[62:1] == '0)
        else $error("index or latency set without a match");

    // The longest group length never shrinks.
    a_max_grows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && seen_reg |-> m_tdata[82:63] >= last_max_reg)
        else $error("longest group length decreased");

    // An overwrite of the oldest entry happens only on a full table.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[90] |-> m_tdata[89:83] == HELD_W'(TABLE_DEPTH))
        else $error("oldest entry dropped while table not full");

endmodule

bind keyframe_latency_index_table kli_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_kli_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/keyframe_latency_index_table_test.sv @@
// ----------------------------------------------------------------------------
// keyframe_latency_index_table_test: self-checking bench for the keyframe table.
// A queue of requests (a short directed set, then segments of well-formed
// add/query/clear traffic with some noise) feeds a bursty stream driver. Each
// accepted request runs through a local model of the table, and the monitor
// compares every result transaction field by field against the oldest
// prediction while the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module keyframe_latency_index_table_test;
    import kli_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int TAIL_CYCLES    = 3 * (2 * DEPTH + 2);
    localparam int WATCHDOG_LIMIT = 4000;

    // Request code with no defined action.
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;
        logic [TS_W-1:0]  ts;
        logic             key;
        logic [LAT_W-1:0] limit;
        logic [IDX_W-1:0] bound;
        logic             drain_first;
    } kli_request_t;

    // One result transaction, field by field.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  gop_index;
        logic [LAT_W-1:0]  gop_latency;
        logic [GLEN_W-1:0] max_len;
        logic [HELD_W-1:0] held;
        logic              dropped;
    } kli_result_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_BUSY,
        RX_PERIODIC
    } rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    kli_request_t pending_requests[$];
    kli_result_t  expected_results[$];

    // Local copy of the table state.
    logic [IDX_W-1:0]  tbl_idx [DEPTH];
    logic [TS_W-1:0]   tbl_ts  [DEPTH];
    int                oldest = 0;
    int                held_cnt = 0;
    logic [TS_W-1:0]   newest_ts = '0;
    logic [GLEN_W-1:0] run_len = '0;
    logic [GLEN_W-1:0] best_len = '0;

    // Run statistics.
    int n_add = 0, n_key = 0, n_query = 0, n_found = 0;
    int n_clear = 0, n_other = 0, n_drop = 0;
    int mismatches = 0;

    int burst_left = 1;
    int gap_left = 0;
    int rx_left = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_cycle = 0;
    int idle_cycles = 0;

    keyframe_latency_index_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply one request to the local table and return the result it yields.
    function automatic kli_result_t predict_request(input kli_request_t rq);
        kli_result_t      r;
        int               k;
        int               s;
        int               kept;
        bit               walking;
        logic [31:0]      diff;
        logic [IDX_W-1:0] keep_idx [DEPTH];
        logic [TS_W-1:0]  keep_ts  [DEPTH];
        r = '0;
        case (rq.req)
            REQ_ADD:
            begin
                n_add++;
                newest_ts = rq.ts;
                if (rq.key)
                begin
                    n_key++;
                    if (held_cnt >= DEPTH)
                    begin
                        s = oldest;
                        oldest = (oldest + 1) % DEPTH;
                        r.dropped = 1'b1;
                        n_drop++;
                    end
                    else
                    begin
                        s = (oldest + held_cnt) % DEPTH;
                        held_cnt++;
                    end
                    tbl_idx[s] = rq.idx;
                    tbl_ts[s]  = rq.ts;
                    if (run_len > best_len)
                        best_len = run_len;
                    run_len = '0;
                end
                if (run_len != GLEN_MAX)
                    run_len = run_len + GLEN_W'(1);
            end
            REQ_QUERY:
            begin
                // Walk back from the newest entry while it stays within the limit.
                n_query++;
                k = held_cnt;
                walking = 1'b1;
                while (walking && k > 0)
                begin
                    s = (oldest + k - 1) % DEPTH;
                    diff = newest_ts - tbl_ts[s];
                    if (diff[31] || diff <= {1'b0, rq.limit})
                    begin
                        r.found       = 1'b1;
                        r.gop_index   = tbl_idx[s];
                        r.gop_latency = diff[31] ? '0 : diff[LAT_W-1:0];
                        k--;
                    end
                    else
                        walking = 1'b0;
                end
                if (r.found)
                    n_found++;
            end
            REQ_CLEAR:
            begin
                // Keep entries above the bound, packed from the oldest slot on.
                n_clear++;
                kept = 0;
                for (k = 0; k < held_cnt; k++)
                begin
                    s = (oldest + k) % DEPTH;
                    if (tbl_idx[s] > rq.bound)
                    begin
                        keep_idx[kept] = tbl_idx[s];
                        keep_ts[kept]  = tbl_ts[s];
                        kept++;
                    end
                end
                for (k = 0; k < kept; k++)
                begin
                    s = (oldest + k) % DEPTH;
                    tbl_idx[s] = keep_idx[k];
                    tbl_ts[s]  = keep_ts[k];
                end
                held_cnt = kept;
            end
            default:
                n_other++;
        endcase
        r.max_len = best_len;
        r.held    = held_cnt[HELD_W-1:0];
        return r;
    endfunction

    task automatic queue_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                                 input logic [TS_W-1:0] ts, input logic key,
                                 input logic [LAT_W-1:0] limit, input logic [IDX_W-1:0] bound,
                                 input logic drain);
        kli_request_t rq;
        rq.req = req;
        rq.idx = idx;
        rq.ts = ts;
        rq.key = key;
        rq.limit = limit;
        rq.bound = bound;
        rq.drain_first = drain;
        pending_requests.push_back(rq);
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        int               made;
        int               seg_mode;
        int               seg_len;
        int               pick;
        int               clear_pct;
        int               key_pct;
        logic             drain;
        logic [IDX_W-1:0] next_idx;
        logic [TS_W-1:0]  cur_ts;
        logic [LAT_W-1:0] limit;
        logic [IDX_W-1:0] bound;

        // Directed: empty table, unused code, extremes, negative latency, clears.
        queue_request(REQ_QUERY, '0, '0, 1'b0, '0, '0, 1'b0);
        queue_request(REQ_CLEAR, '0, '0, 1'b0, '0, '1, 1'b0);
        queue_request(REQ_SPARE, '1, '1, 1'b1, '1, '1, 1'b0);
        queue_request(REQ_ADD, '0, '0, 1'b0, '0, '0, 1'b0);
        queue_request(REQ_ADD, '0, '0, 1'b1, '0, '0, 1'b0);
        queue_request(REQ_ADD, '1, '1, 1'b1, '1, '1, 1'b0);
        queue_request(REQ_ADD, 31'd5, 32'd1000, 1'b1, '0, '0, 1'b0);
        queue_request(REQ_ADD, 31'd6, 32'd500, 1'b0, '0, '0, 1'b0);
        queue_request(REQ_QUERY, '0, '0, 1'b0, '0, '0, 1'b0);
        queue_request(REQ_QUERY, '1, '1, 1'b1, '1, '1, 1'b0);
        queue_request(REQ_ADD, 31'd8, 32'd600, 1'b1, '0, '0, 1'b0);
        queue_request(REQ_QUERY, '0, '0, 1'b0, 31'd100, '0, 1'b0);
        queue_request(REQ_CLEAR, '0, '0, 1'b0, '0, 31'd5, 1'b0);
        queue_request(REQ_QUERY, '0, '0, 1'b0, '1, '0, 1'b0);
        queue_request(REQ_CLEAR, '0, '0, 1'b0, '0, '0, 1'b0);
        queue_request(REQ_SPARE, '0, '0, 1'b0, '0, '0, 1'b0);
        queue_request(REQ_CLEAR, '0, '0, 1'b0, '0, '1, 1'b0);
        queue_request(REQ_QUERY, '0, '0, 1'b0, '1, '0, 1'b0);

        // Random segments: table fills, mixed traffic, clear-heavy, and noise.
        made = 0;
        next_idx = '0;
        cur_ts = '0;
        while (made < RANDOM_ITEMS)
        begin
            seg_mode = $urandom_range(0, 7);
            seg_len  = $urandom_range(30, 120);
            if ($urandom_range(0, 3) == 0)
                next_idx = IDX_W'($urandom);
            if ($urandom_range(0, 3) == 0)
                cur_ts = $urandom;
            clear_pct = (seg_mode < 3) ? 0 : ((seg_mode < 5) ? 8 : 25);
            key_pct   = (seg_mode < 3) ? 75 : 30;
            repeat (seg_len)
            begin
                drain = (made == 0) || ($urandom_range(0, 199) == 0);
                pick  = $urandom_range(0, 99);
                if (seg_mode == 7)
                    queue_request(REQ_W'($urandom_range(0, 3)), IDX_W'($urandom), $urandom,
                                  1'($urandom_range(0, 1)), LAT_W'($urandom),
                                  IDX_W'($urandom), drain);
                else if (pick < 20)
                begin
                    case ($urandom_range(0, 3))
                        0: limit = LAT_W'($urandom_range(0, 500));
                        1: limit = LAT_W'($urandom_range(0, 5000));
                        2: limit = LAT_W'($urandom);
                        default: limit = '0;
                    endcase
                    queue_request(REQ_QUERY, IDX_W'($urandom), $urandom,
                                  1'($urandom_range(0, 1)), limit, IDX_W'($urandom), drain);
                end
                else if (pick < 20 + clear_pct)
                begin
                    case ($urandom_range(0, 5))
                        0: bound = IDX_W'($urandom);
                        1: bound = '0;
                        2: bound = '1;
                        default: bound = next_idx - IDX_W'($urandom_range(0, 150));
                    endcase
                    queue_request(REQ_CLEAR, IDX_W'($urandom), $urandom,
                                  1'($urandom_range(0, 1)), LAT_W'($urandom), bound, drain);
                end
                else if (pick >= 98)
                    queue_request(REQ_SPARE, IDX_W'($urandom), $urandom,
                                  1'($urandom_range(0, 1)), LAT_W'($urandom),
                                  IDX_W'($urandom), drain);
                else
                begin
                    // Time mostly moves forward; a step back gives negative latency.
                    if ($urandom_range(0, 19) == 0)
                        cur_ts = cur_ts - $urandom_range(1, 200);
                    else
                        cur_ts = cur_ts + $urandom_range(0, 40);
                    queue_request(REQ_ADD, next_idx, cur_ts, $urandom_range(0, 99) < key_pct,
                                  LAT_W'($urandom), IDX_W'($urandom), drain);
                    next_idx = next_idx + IDX_W'($urandom_range(1, 3));
                end
                made++;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all traffic to drain, then give the block time to go quiet.
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d adds (%0d keyframes), %0d queries, %0d clears, %0d unused.",
                 n_add + n_query + n_clear + n_other, n_add, n_key, n_query, n_clear, n_other);
        $display("Saw %0d full-table overwrites and %0d successful lookups.", n_drop, n_found);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Bursty request driver; a flagged request waits until all results are back.
    always @(posedge clk or negedge rst_n)
    begin
        bit taken;
        bit holding;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            taken = s_tvalid && s_tready;
            if (taken)
            begin
                expected_results.push_back(predict_request(pending_requests.pop_front()));
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                end
            end
            holding = s_tvalid && !taken;
            if (!holding)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].drain_first || expected_results.size() == 0))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_DATA_W - S_DATA_BITS){1'b0}}, pending_requests[0].bound,
                                 pending_requests[0].limit, pending_requests[0].ts,
                                 pending_requests[0].idx};
                    s_tuser  <= {{(S_USER_W - REQ_W - 1){1'b0}}, pending_requests[0].key,
                                 pending_requests[0].req};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready pattern, switching between stall modes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle++;
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            else
                rx_left--;
            case (rx_mode)
                RX_OPEN:     m_tready <= 1'b1;
                RX_SPARSE:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_BUSY:     m_tready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_tready <= rx_cycle[4];
            endcase
        end
    end

    // Result monitor: compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        kli_result_t got;
        kli_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found       = m_tdata[0];
            got.gop_index   = m_tdata[31:1];
            got.gop_latency = m_tdata[62:32];
            got.max_len     = m_tdata[82:63];
            got.held        = m_tdata[89:83];
            got.dropped     = m_tdata[90];
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    mismatches++;
                end
                if (got.gop_index !== want.gop_index)
                begin
                    $error("gop_index: expected %0d, got %0d", want.gop_index, got.gop_index);
                    mismatches++;
                end
                if (got.gop_latency !== want.gop_latency)
                begin
                    $error("gop_latency: expected %0d, got %0d", want.gop_latency,
                           got.gop_latency);
                    mismatches++;
                end
                if (got.max_len !== want.max_len)
                begin
                    $error("max_gop_length: expected %0d, got %0d", want.max_len, got.max_len);
                    mismatches++;
                end
                if (got.held !== want.held)
                begin
                    $error("entries_held: expected %0d, got %0d", want.held, got.held);
                    mismatches++;
                end
                if (got.dropped !== want.dropped)
                begin
                    $error("dropped_oldest: expected %0d, got %0d", want.dropped, got.dropped);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

@@ sim.f @@
rtl/kli_pkg.sv
rtl/kli_cell.sv
rtl/kli_head.sv
rtl/keyframe_latency_index_table.sv
rtl/kli_checker.sv
tb/keyframe_latency_index_table_test.sv
